>>> rtl/pvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pvc_pkg;

   // operation of one queued item, set by the front from the input kind
   localparam logic OP_START   = 1'b0;
   localparam logic OP_MEASURE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/pvc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pvc_front
   import pvc_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input item
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic                  in_kind,
   input  wire logic [COUNT_BITS-1:0] in_target,
   input  wire logic [COUNT_BITS-1:0] in_measured,
   // classified item towards the back
   output logic                       q_valid,
   input  wire logic                  q_ready,
   output logic                       q_op,
   output logic [COUNT_BITS-1:0]      q_count
);

   localparam int ItemBits = COUNT_BITS + 1;

   logic [ItemBits-1:0] slot_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          fill_ff;
   logic [1:0]          fill_in;
   logic                push;
   logic                pop;
   logic                op;
   logic [COUNT_BITS-1:0] count;

   // classify: a start keeps the target, a measurement keeps the count
   always_comb begin
      op    = in_kind ? OP_MEASURE : OP_START;
      count = (op == OP_START) ? in_target : in_measured;
   end

   assign in_ready = (fill_ff != 2'd2);
   assign q_valid  = (fill_ff != 2'd0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_op     = slot_ff[rd_ptr_ff][ItemBits-1];
   assign q_count  = slot_ff[rd_ptr_ff][COUNT_BITS-1:0];

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= {op, count};
      end
   end

endmodule

`default_nettype wire

>>> rtl/pvc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pvc_back
   import pvc_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int CODE_BITS  = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // classified item from the front
   input  wire logic                  q_valid,
   output logic                       q_ready,
   input  wire logic                  q_op,
   input  wire logic [COUNT_BITS-1:0] q_count,
   // result item
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [CODE_BITS-1:0]       out_probe,
   output logic                       out_request,
   output logic                       out_done,
   output logic [CODE_BITS-1:0]       out_chosen,
   output logic                       out_unexpected
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SEARCH = 2'd1;
   localparam logic [1:0] PH_LOW    = 2'd2;
   localparam logic [1:0] PH_HIGH   = 2'd3;

   localparam logic [CODE_BITS-1:0] CODE_START = {1'b1, {(CODE_BITS-1){1'b0}}};
   localparam logic [CODE_BITS-1:0] CODE_MAX   = {CODE_BITS{1'b1}};
   localparam logic [CODE_BITS-2:0] STEP_START = {1'b1, {(CODE_BITS-2){1'b0}}};

   logic [1:0]            phase_ff, phase_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic [CODE_BITS-2:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] target_ff, target_in;
   logic [COUNT_BITS-1:0] cdev_ff, cdev_in;
   logic [COUNT_BITS-1:0] ldev_ff, ldev_in;
   logic                  valid_ff;
   logic [CODE_BITS-1:0]  probe_ff, probe_in;
   logic                  request_ff, request_in;
   logic                  done_ff, done_in;
   logic [CODE_BITS-1:0]  chosen_ff, chosen_in;
   logic                  unexp_ff, unexp_in;

   logic                  take;
   logic [COUNT_BITS-1:0] dev;
   logic [CODE_BITS-1:0]  stepped_code;
   logic [CODE_BITS-2:0]  halved_step;

   function automatic logic [CODE_BITS-1:0] low_of(input logic [CODE_BITS-1:0] c);
      low_of = (c == '0) ? '0 : c - {{(CODE_BITS-1){1'b0}}, 1'b1};
   endfunction

   function automatic logic [CODE_BITS-1:0] high_of(input logic [CODE_BITS-1:0] c);
      high_of = (c == CODE_MAX) ? CODE_MAX : c + {{(CODE_BITS-1){1'b0}}, 1'b1};
   endfunction

   // the output slot frees when empty or when its item is taken
   assign take      = q_valid && (!valid_ff || out_ready);
   assign q_ready   = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   // absolute deviation of the incoming count from the target
   assign dev = (q_count < target_ff) ? (target_ff - q_count) : (q_count - target_ff);

   // one binary search step
   always_comb begin
      stepped_code = code_ff;
      if (q_count < target_ff) begin
         stepped_code = code_ff + {1'b0, step_ff};
      end else if (q_count > target_ff) begin
         stepped_code = code_ff - {1'b0, step_ff};
      end
      halved_step = step_ff >> 1;
   end

   // calibration sequencer
   always_comb begin
      phase_in   = phase_ff;
      code_in    = code_ff;
      step_in    = step_ff;
      target_in  = target_ff;
      cdev_in    = cdev_ff;
      ldev_in    = ldev_ff;
      probe_in   = '0;
      request_in = 1'b0;
      done_in    = 1'b0;
      chosen_in  = '0;
      unexp_in   = 1'b0;
      if (q_op == OP_START) begin
         target_in  = q_count;
         code_in    = CODE_START;
         step_in    = STEP_START;
         cdev_in    = '0;
         ldev_in    = '0;
         phase_in   = PH_SEARCH;
         probe_in   = CODE_START;
         request_in = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_SEARCH: begin
               code_in    = stepped_code;
               cdev_in    = dev;
               step_in    = halved_step;
               request_in = 1'b1;
               if (halved_step != '0) begin
                  probe_in = stepped_code;
               end else begin
                  probe_in = low_of(stepped_code);
                  phase_in = PH_LOW;
               end
            end
            PH_LOW: begin
               ldev_in    = dev;
               probe_in   = high_of(code_ff);
               request_in = 1'b1;
               phase_in   = PH_HIGH;
            end
            PH_HIGH: begin
               // low neighbor wins ties, then high, else the center
               if (ldev_ff <= cdev_ff && ldev_ff <= dev) begin
                  chosen_in = low_of(code_ff);
               end else if (dev <= cdev_ff && dev <= ldev_ff) begin
                  chosen_in = high_of(code_ff);
               end else begin
                  chosen_in = code_ff;
               end
               probe_in = chosen_in;
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               unexp_in = 1'b1;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         valid_ff <= 1'b0;
         code_ff  <= '0;
         step_ff  <= '0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            code_ff  <= code_in;
            step_ff  <= step_in;
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // search data and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         cdev_ff   <= '0;
         ldev_ff   <= '0;
      end else if (take) begin
         target_ff <= target_in;
         cdev_ff   <= cdev_in;
         ldev_ff   <= ldev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         probe_ff   <= probe_in;
         request_ff <= request_in;
         done_ff    <= done_in;
         chosen_ff  <= chosen_in;
         unexp_ff   <= unexp_in;
      end
   end

   assign out_probe      = probe_ff;
   assign out_request    = request_ff;
   assign out_done       = done_ff;
   assign out_chosen     = chosen_ff;
   assign out_unexpected = unexp_ff;

endmodule

`default_nettype wire

>>> rtl/pll_vco_band_calibrator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// VCO band calibrator: a start item (tuser 0) loads the target count and
// proposes the middle band code; each measured count (tuser 1) then steps a
// binary search of the code, the two neighbors of the final code are
// probed, and the item after the high neighbor returns the code of least
// deviation with done set. Every item gives exactly one result item. Items
// are accepted one per cycle while the queue is not full: a two-entry queue
// sits between the input stage and the sequencer, and the sequencer does one
// full update per item, so an accepted item is stored in the queue and its
// result then in the output register, and the block accepts up to two more
// items while a result waits in the output register.
module pll_vco_band_calibrator_unit #(
   parameter int COUNT_BITS = 16,
   parameter int CODE_BITS  = 5
) (
   input  wire logic clock,
   input  wire logic reset,
   // input items
   input  wire logic req_tvalid,
   output logic      req_tready,
   // target_count, measured_count, zero padding
   input  wire logic [((2*COUNT_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  wire logic [0:0] req_tuser,
   // result items
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // probe_code, measure_request, done_res, chosen_code, unexpected, zero padding
   output logic [((2*CODE_BITS+3+7)/8)*8-1:0] rsp_tdata
);

   localparam int RspBits = ((2*CODE_BITS+3+7)/8)*8;
   localparam int RspUsed = 2*CODE_BITS + 3;

   logic                  q_valid;
   logic                  q_ready;
   logic                  q_op;
   logic [COUNT_BITS-1:0] q_count;
   logic [CODE_BITS-1:0]  probe;
   logic                  request;
   logic                  done;
   logic [CODE_BITS-1:0]  chosen;
   logic                  unexpected;

   // accept and classify items into the queue
   pvc_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser[0]),
      .in_target  (req_tdata[COUNT_BITS-1:0]),
      .in_measured(req_tdata[2*COUNT_BITS-1:COUNT_BITS]),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_op       (q_op),
      .q_count    (q_count)
   );

   // run the search and hold the result
   pvc_back #(
      .COUNT_BITS(COUNT_BITS),
      .CODE_BITS (CODE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_op          (q_op),
      .q_count       (q_count),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_probe     (probe),
      .out_request   (request),
      .out_done      (done),
      .out_chosen    (chosen),
      .out_unexpected(unexpected)
   );

   // pack result fields from the lowest bit up
   assign rsp_tdata = {{(RspBits-RspUsed){1'b0}}, unexpected, chosen, done, request, probe};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// search state of the band calibration as seen from outside
typedef enum logic [1:0] {
   CAL_IDLE,
   CAL_SEARCH,
   CAL_LOW,
   CAL_HIGH
} cal_phase_type;

// one result item, unpacked
typedef struct {
   logic [4:0] probe_code;
   logic       measure_request;
   logic       done_res;
   logic [4:0] chosen_code;
   logic       unexpected;
} band_result_type;

// tracks the calibration state and checks every result item in order
class band_cal_scoreboard;
   localparam logic [4:0] CODE_MID  = 5'd16;
   localparam logic [4:0] CODE_TOP  = 5'd31;
   localparam logic [3:0] STEP_INIT = 4'd8;

   cal_phase_type   phase;
   logic [4:0]      code;
   logic [3:0]      step;
   logic [15:0]     target;
   logic [15:0]     centre_dev;
   logic [15:0]     low_dev;
   band_result_type pending_band_results[$];
   int              errors;
   int              items_seen;
   int              results_seen;
   int              calibrations_done;
   int              stray_measurements;

   function new();
      phase = CAL_IDLE;
      code = '0;
      step = '0;
      target = '0;
      centre_dev = '0;
      low_dev = '0;
      errors = 0;
      items_seen = 0;
      results_seen = 0;
      calibrations_done = 0;
      stray_measurements = 0;
   endfunction

   function logic [15:0] deviation(logic [15:0] count);
      return (count < target) ? target - count : count - target;
   endfunction

   function logic [4:0] low_neighbour();
      return (code == 5'd0) ? 5'd0 : code - 5'd1;
   endfunction

   function logic [4:0] high_neighbour();
      return (code == CODE_TOP) ? CODE_TOP : code + 5'd1;
   endfunction

   // advance the calibration by one accepted item and queue its result
   function void note_item(logic kind, logic [15:0] tgt, logic [15:0] meas);
      band_result_type r;
      logic [15:0]     high_dev;
      r = '{default: '0};
      items_seen++;
      if (kind == pvc_pkg::OP_START) begin
         target = tgt;
         code = CODE_MID;
         step = STEP_INIT;
         centre_dev = '0;
         low_dev = '0;
         phase = CAL_SEARCH;
         r.probe_code = code;
         r.measure_request = 1'b1;
      end else begin
         case (phase)
            CAL_SEARCH: begin
               if (meas < target)
                  code = code + 5'(step);
               else if (meas > target)
                  code = code - 5'(step);
               centre_dev = deviation(meas);
               step = step >> 1;
               if (step != 0) begin
                  r.probe_code = code;
               end else begin
                  r.probe_code = low_neighbour();
                  phase = CAL_LOW;
               end
               r.measure_request = 1'b1;
            end
            CAL_LOW: begin
               low_dev = deviation(meas);
               r.probe_code = high_neighbour();
               r.measure_request = 1'b1;
               phase = CAL_HIGH;
            end
            CAL_HIGH: begin
               high_dev = deviation(meas);
               // low neighbor wins ties, then high, else the center
               if (low_dev <= centre_dev && low_dev <= high_dev)
                  r.chosen_code = low_neighbour();
               else if (high_dev <= centre_dev && high_dev <= low_dev)
                  r.chosen_code = high_neighbour();
               else
                  r.chosen_code = code;
               r.probe_code = r.chosen_code;
               r.done_res = 1'b1;
               phase = CAL_IDLE;
               calibrations_done++;
            end
            default: begin
               r.unexpected = 1'b1;
               stray_measurements++;
            end
         endcase
      end
      pending_band_results.push_back(r);
   endfunction

   function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         errors++;
      end
   endfunction

   // compare a result item against the oldest queued prediction
   function void check_result(logic [15:0] data);
      band_result_type e;
      results_seen++;
      if (pending_band_results.size() == 0) begin
         $error("result item 0x%04h arrived with no prediction waiting", data);
         errors++;
         return;
      end
      e = pending_band_results.pop_front();
      compare_field("probe_code", e.probe_code, data[4:0]);
      compare_field("measure_request", e.measure_request, data[5]);
      compare_field("done_res", e.done_res, data[6]);
      compare_field("chosen_code", e.chosen_code, data[11:7]);
      compare_field("unexpected", e.unexpected, data[12]);
   endfunction
endclass

module tb_top;
   import pvc_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_GAP      = 40;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // target_count, measured_count
   logic [0:0]  req_tuser;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // probe_code, measure_request, done_res, chosen_code, unexpected

   int sender_idle_pct;
   int receiver_stall_pct;
   int quiet_cycles;

   band_cal_scoreboard sb = new();

   pll_vco_band_calibrator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock, first rising edge at 5 ns
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // watch both channels, score results, catch a hung block
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_item(req_tuser[0], req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("pll_vco_band_calibrator_unit regression: fail");
            $finish;
         end
      end
   end

   // offer one item after a random idle gap and wait for it to be taken
   task automatic send_item(input logic kind, input logic [15:0] tgt, input logic [15:0] meas);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {meas, tgt};
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // full calibration: start, four search counts, low and high neighbor counts
   task automatic run_calibration(input logic [15:0] tgt, input logic [15:0] m0,
                                  input logic [15:0] m1, input logic [15:0] m2,
                                  input logic [15:0] m3, input logic [15:0] m_low,
                                  input logic [15:0] m_high);
      send_item(OP_START, tgt, 16'h0000);
      send_item(OP_MEASURE, 16'hFFFF, m0);
      send_item(OP_MEASURE, 16'h0000, m1);
      send_item(OP_MEASURE, 16'hFFFF, m2);
      send_item(OP_MEASURE, 16'h0000, m3);
      send_item(OP_MEASURE, 16'hFFFF, m_low);
      send_item(OP_MEASURE, 16'h0000, m_high);
   endtask

   function automatic logic [15:0] pick_target();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // counts near the target so that equal deviations and exact hits are common
   function automatic logic [15:0] pick_count(input logic [15:0] tgt);
      case ($urandom_range(7))
         0, 1: return tgt;
         2, 3, 4: return tgt + 16'($urandom_range(6)) - 16'd3;
         5: return tgt + 16'($urandom_range(510)) - 16'd255;
         6: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      int sent;
      int n_meas;
      logic [15:0] tgt;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // measurement while idle
      send_item(OP_MEASURE, 16'h0000, 16'h0000);
      // zero target, exact hits keep the code, all deviations tie
      run_calibration(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000);
      // top target, search runs to the top code, high neighbor clamps
      run_calibration(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'hFFFF);
      // search runs to the bottom, low neighbor is code zero
      run_calibration(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'h8001, 16'h7FFF);
      // restart while busy, then center wins on the last search trial
      send_item(OP_START, 16'h1234, 16'hFFFF);
      send_item(OP_MEASURE, 16'h0000, 16'h1234);
      run_calibration(16'h0F0F, 16'h0F00, 16'h0F20, 16'h0F00, 16'h0F0E,
                      16'h0000, 16'hFFFF);
      send_item(OP_MEASURE, 16'hFFFF, 16'hFFFF);

      // random calibrations with some noise, over four idling mixes
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ((sent * 4) / RANDOM_ITEMS)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 55;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 55;
            end
            default: begin
               sender_idle_pct = 25;
               receiver_stall_pct = 25;
            end
         endcase
         if ($urandom_range(9) < 8) begin
            tgt = pick_target();
            send_item(OP_START, tgt, 16'($urandom));
            // now and then cut the calibration short
            n_meas = ($urandom_range(9) == 0) ? $urandom_range(5) : 6;
            for (int i = 0; i < n_meas; i++)
               send_item(OP_MEASURE, 16'($urandom), pick_count(tgt));
            sent += 1 + n_meas;
         end else begin
            send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.pending_band_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d items and %0d results: %0d finished calibrations, %0d stray counts",
               sb.items_seen, sb.results_seen, sb.calibrations_done, sb.stray_measurements);
      $display("idling mixes: none, sender 55%%, receiver 55%%, both 25%%; %0d mismatches",
               sb.errors);
      if (sb.errors == 0 && sb.pending_band_results.size() == 0) begin
         $display("pll_vco_band_calibrator_unit regression: pass");
      end else begin
         $display("pll_vco_band_calibrator_unit regression: fail");
      end
      $finish;
   end

endmodule
